// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Each one samples on the rising edge and
// is disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever cond holds, prop holds too.
`define ASSERT_IMPL(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication: whenever cond holds, prop holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rstn, cond, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)

`endif

`endif

// ===== rtl/nta_pkg.sv =====
package nta_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [15:0] HOLD_TICKS_RST = 16'd4;

    // configuration register indexes
    localparam logic [1:0] REG_HOLD_TICKS     = 2'd0;
    localparam logic [1:0] REG_LOCAL_NODE_ID  = 2'd1;
    localparam logic [1:0] REG_NODE_REGISTERED = 2'd2;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ENTRY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_REFRESHED = 2'd0,
        STAT_ADDED     = 2'd1,
        STAT_DROPPED   = 2'd2
    } status_t;

    // one neighbor slot as it travels around the ring
    typedef struct packed {
        logic        valid;
        logic [15:0] node;
        logic [7:0]  sif;
        logic [7:0]  rif;
        logic [15:0] age;
    } slot_t;

endpackage

// ===== rtl/nta_cell.sv =====
module nta_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           shift_en,
    input  nta_pkg::slot_t slot_in,
    output nta_pkg::slot_t slot_out
);
    import nta_pkg::*;

    logic        valid_reg;
    logic [15:0] node_reg;
    logic [7:0]  sif_reg;
    logic [7:0]  rif_reg;
    logic [15:0] age_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= slot_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            node_reg <= slot_in.node;
            sif_reg  <= slot_in.sif;
            rif_reg  <= slot_in.rif;
            age_reg  <= slot_in.age;
        end
    end

    always_comb begin
        slot_out.valid = valid_reg;
        slot_out.node  = node_reg;
        slot_out.sif   = sif_reg;
        slot_out.rif   = rif_reg;
        slot_out.age   = age_reg;
    end

endmodule

// ===== rtl/nta_ctrl.sv =====
`include "assert_macros.svh"

module nta_ctrl #(
    parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_wr_index,
    input  logic [15:0]    cfg_wr_data,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,
    input  logic           s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [39:0]    m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast,
    input  nta_pkg::slot_t head,
    output nta_pkg::slot_t feedback,
    output logic           shift_en
);
    import nta_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_FILL,
        ST_ANN_OUT,
        ST_HDR,
        ST_SCAN
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             ovf_reg, ovf_next;
    logic             found_reg, found_next;
    logic             free_reg, free_next;
    logic             filled_reg, filled_next;
    status_t          status_reg, status_next;

    logic [15:0]      hold_reg, hold_next;
    logic [15:0]      local_reg, local_next;
    logic             reg_en_reg, reg_en_next;

    logic [15:0]      key_node_reg, key_node_next;
    logic [7:0]       key_sif_reg, key_sif_next;
    logic [7:0]       key_rif_reg, key_rif_next;

    logic             m_valid_reg, m_valid_next;
    kind_t            m_kind_reg, m_kind_next;
    status_t          m_status_reg, m_status_next;
    logic [15:0]      m_node_reg, m_node_next;
    logic [7:0]       m_sif_reg, m_sif_next;
    logic [7:0]       m_rif_reg, m_rif_next;
    logic             m_ovf_reg, m_ovf_next;
    logic [4:0]       m_cnt_reg, m_cnt_next;
    logic             m_last_reg, m_last_next;

    logic             out_free;
    logic             out_load;
    logic             head_match;
    logic             last_pos;
    logic             need_emit;
    logic [31:0]      cnt_wide;

    assign out_free   = !m_valid_reg || m_tready;
    assign last_pos   = (pos_reg == LAST_POS);
    assign head_match = head.valid && (head.node == key_node_reg)
                        && (head.sif == key_sif_reg) && (head.rif == key_rif_reg);
    assign need_emit  = reg_en_reg && head.valid;
    assign cnt_wide   = 32'(cnt_reg);
    assign s_tready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        ovf_next      = ovf_reg;
        found_next    = found_reg;
        free_next     = free_reg;
        filled_next   = filled_reg;
        status_next   = status_reg;
        hold_next     = hold_reg;
        local_next    = local_reg;
        reg_en_next   = reg_en_reg;
        key_node_next = key_node_reg;
        key_sif_next  = key_sif_reg;
        key_rif_next  = key_rif_reg;
        m_valid_next  = m_valid_reg;
        m_kind_next   = m_kind_reg;
        m_status_next = m_status_reg;
        m_node_next   = m_node_reg;
        m_sif_next    = m_sif_reg;
        m_rif_next    = m_rif_reg;
        m_ovf_next    = m_ovf_reg;
        m_cnt_next    = m_cnt_reg;
        m_last_next   = m_last_reg;
        shift_en      = 1'b0;
        feedback      = head;
        out_load      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_HOLD_TICKS:      hold_next   = cfg_wr_data;
                REG_LOCAL_NODE_ID:   local_next  = cfg_wr_data;
                REG_NODE_REGISTERED: reg_en_next = cfg_wr_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                pos_next = '0;
                if (s_tvalid) begin
                    key_node_next = s_tdata[15:0];
                    key_sif_next  = s_tdata[23:16];
                    key_rif_next  = s_tdata[31:24];
                    found_next    = 1'b0;
                    free_next     = 1'b0;
                    filled_next   = 1'b0;
                    rem_next      = cnt_reg;
                    if (!s_tuser) begin
                        state_next = ST_FIND;
                    end else if (reg_en_reg) begin
                        state_next = ST_HDR;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // first lap: refresh a matching entry, note whether any slot is free
            ST_FIND: begin
                shift_en = 1'b1;
                pos_next = pos_reg + IDX_W'(1);
                if (head_match) begin
                    feedback.age = hold_reg;
                    found_next   = 1'b1;
                end
                if (!head.valid) begin
                    free_next = 1'b1;
                end
                if (last_pos) begin
                    pos_next = '0;
                    if (found_next) begin
                        status_next = STAT_REFRESHED;
                        state_next  = ST_ANN_OUT;
                    end else if (free_next) begin
                        state_next = ST_FILL;
                    end else begin
                        ovf_next    = 1'b1;
                        status_next = STAT_DROPPED;
                        state_next  = ST_ANN_OUT;
                    end
                end
            end

            // second lap: the first free slot to pass the head takes the entry
            ST_FILL: begin
                shift_en = 1'b1;
                pos_next = pos_reg + IDX_W'(1);
                if (!head.valid && !filled_reg) begin
                    feedback.valid = 1'b1;
                    feedback.node  = key_node_reg;
                    feedback.sif   = key_sif_reg;
                    feedback.rif   = key_rif_reg;
                    feedback.age   = hold_reg;
                    filled_next    = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
                if (last_pos) begin
                    pos_next    = '0;
                    status_next = STAT_ADDED;
                    state_next  = ST_ANN_OUT;
                end
            end

            ST_ANN_OUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_STATUS;
                    m_status_next = status_reg;
                    m_node_next   = '0;
                    m_sif_next    = '0;
                    m_rif_next    = '0;
                    m_ovf_next    = 1'b0;
                    m_cnt_next    = '0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_HDR: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_HEADER;
                    m_status_next = STAT_REFRESHED;
                    m_node_next   = local_reg;
                    m_sif_next    = '0;
                    m_rif_next    = '0;
                    m_ovf_next    = ovf_reg;
                    m_cnt_next    = cnt_wide[4:0];
                    m_last_next   = (cnt_reg == '0);
                    state_next    = ST_SCAN;
                end
            end

            // one lap: report each valid entry if reports are on, then age it
            ST_SCAN: begin
                if (!need_emit || out_free) begin
                    shift_en = 1'b1;
                    pos_next = pos_reg + IDX_W'(1);
                    if (need_emit) begin
                        out_load      = 1'b1;
                        m_valid_next  = 1'b1;
                        m_kind_next   = KIND_ENTRY;
                        m_status_next = STAT_REFRESHED;
                        m_node_next   = head.node;
                        m_sif_next    = head.sif;
                        m_rif_next    = head.rif;
                        m_ovf_next    = 1'b0;
                        m_cnt_next    = '0;
                        m_last_next   = (rem_reg == CNT_W'(1));
                        rem_next      = rem_reg - CNT_W'(1);
                    end
                    if (head.valid) begin
                        if (head.age <= 16'd1) begin
                            feedback.valid = 1'b0;
                            feedback.age   = '0;
                            ovf_next       = 1'b0;
                            cnt_next       = cnt_reg - CNT_W'(1);
                        end else begin
                            feedback.age = head.age - 16'd1;
                        end
                    end
                    if (last_pos) begin
                        pos_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            ovf_reg     <= 1'b0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            filled_reg  <= 1'b0;
            hold_reg    <= HOLD_TICKS_RST;
            local_reg   <= '0;
            reg_en_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            ovf_reg     <= ovf_next;
            found_reg   <= found_next;
            free_reg    <= free_next;
            filled_reg  <= filled_next;
            hold_reg    <= hold_next;
            local_reg   <= local_next;
            reg_en_reg  <= reg_en_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        key_node_reg <= key_node_next;
        key_sif_reg  <= key_sif_next;
        key_rif_reg  <= key_rif_next;
        m_kind_reg   <= m_kind_next;
        m_status_reg <= m_status_next;
        m_node_reg   <= m_node_next;
        m_sif_reg    <= m_sif_next;
        m_rif_reg    <= m_rif_next;
        m_ovf_reg    <= m_ovf_next;
        m_cnt_reg    <= m_cnt_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_cnt_reg, m_ovf_reg, m_rif_reg, m_sif_reg, m_node_reg, m_status_reg};

    `ASSERT_IMPL(a_no_overwrite, aclk, aresetn, out_load, !m_valid_reg || m_tready, "result item overwritten while stalled")
    `ASSERT_IMPL(a_idle_aligned, aclk, aresetn, state_reg == ST_IDLE, pos_reg == '0, "ring not aligned when idle")
    `ASSERT_IMPL(a_count_range, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
    `ASSERT_NEXT(a_announce_start, aclk, aresetn, s_tvalid && s_tready && !s_tuser, state_reg == ST_FIND, "announce item did not start a lookup lap")

endmodule

// ===== rtl/neighbor_table_aging_unit.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata: sender_node, sender_interface, receive_interface
//                                   tuser: command
// m_        out  m_tvalid/m_tready  tdata: status, node, entry ifaces, overflow, entry_count
//                                   tuser: kind, tlast: last
// cfg_wr_   in   cfg_wr_en          index 0 hold_ticks, 1 local_node_id, 2 node_registered
//
// The table is a ring of TABLE_DEPTH cells rotating one cell per cycle past one
// head position while a pass is under way and the ring is not held.
// Announce: one lookup lap, a second lap to fill a free slot on add, then a status item.
// Tick: a header item when reports are enabled, then one lap that ages entries and reports them when enabled.
// Reset is synchronous and clears every cell's valid bit; no clearing pass.
// A stalled result channel holds the ring only when the head entry must be reported.
module neighbor_table_aging_unit #(
    parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sender_node, [23:16] sender_interface,
                                   // [31:24] receive_interface
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] status, [17:2] node, [25:18] entry_sender_interface,
                                   // [33:26] entry_receive_interface, [34] overflow,
                                   // [39:35] entry_count
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import nta_pkg::*;

    slot_t ring [TABLE_DEPTH];
    slot_t feedback;
    logic  shift_en;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        slot_t cell_in;
        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign cell_in = feedback;
        end else begin : g_body
            assign cell_in = ring[i+1];
        end
        nta_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .slot_in  (cell_in),
            .slot_out (ring[i])
        );
    end

    nta_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .head         (ring[0]),
        .feedback     (feedback),
        .shift_en     (shift_en)
    );

endmodule
